// ===== hw/rtl/lr_pkg.sv =====
// lr_pkg: shared types and constants for the line rasterizer
// holds the line request and pixel result structs, register codes and field widths
// no dependencies
package lr_pkg;

    localparam int COORD_W = 6;
    localparam int WIN_W   = 7;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic REG_WINDOW_WIDTH  = 1'b0;
    localparam logic REG_WINDOW_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [7:0] start_x;
        logic signed [7:0] start_y;
        logic signed [7:0] end_x;
        logic signed [7:0] end_y;
        logic [7:0]        pen_color;
    } lr_line_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [7:0]         pixel_color;
        logic               bad_endpoint;
        logic               last_pixel;
    } lr_pixel_t;

endpackage

// ===== hw/rtl/line_rasterizer.sv =====
// line_rasterizer: steps one line request into its pixel writes with per-axis error accumulators
// depends on lr_pkg for the request and result structs
// a request is registered on acceptance, set up in ST_SETUP, and its first pixel is registered in ST_RUN
// throughput: one pixel per cycle while the output is free (not holding a pixel with m_ready low),
// set by the single step unit that updates both accumulators once per pixel
// a new request is taken only after the last pixel of the current line has been registered
// reset: synchronous active-low aresetn; window registers return to 64, output empties
module line_rasterizer
    import lr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lr_line_t    s_line,
    output logic        m_valid,
    input  logic        m_ready,
    output lr_pixel_t   m_pixel,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [WIN_W-1:0] MAX_W = WIN_W'(MAX_WIDTH);
    localparam logic [WIN_W-1:0] MAX_H = WIN_W'(MAX_HEIGHT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    state_t              state_reg;
    logic [WIN_W-1:0]    width_reg;
    logic [WIN_W-1:0]    height_reg;
    lr_line_t            line_reg;
    logic                bad_reg;
    logic [COORD_W-1:0]  x_reg, y_reg;
    logic [COORD_W-1:0]  dx_reg, dy_reg, dist_reg, cnt_reg;
    logic                sx_neg_reg, sy_neg_reg;
    logic [WIN_W-1:0]    ex_reg, ey_reg;
    logic                m_valid_reg;
    lr_pixel_t           m_pixel_reg;

    logic [WIN_W-1:0]    w_lim, h_lim;
    logic                bad;
    logic [WIN_W-1:0]    diff_x, diff_y;
    logic [COORD_W-1:0]  adx, ady, span;
    logic [WIN_W-1:0]    ex_sum, ey_sum, ex_next, ey_next;
    logic                step_x, step_y;
    logic                out_free;
    logic                cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIN_W'(64);
            height_reg <= WIN_W'(64);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WINDOW_WIDTH:  width_reg  <= pwdata[WIN_W-1:0];
                REG_WINDOW_HEIGHT: height_reg <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WINDOW_WIDTH:  prdata = {{(32-WIN_W){1'b0}}, width_reg};
            REG_WINDOW_HEIGHT: prdata = {{(32-WIN_W){1'b0}}, height_reg};
            default:           prdata = '0;
        endcase
    end

    // window check and deltas
    assign w_lim = (width_reg > MAX_W) ? MAX_W : width_reg;
    assign h_lim = (height_reg > MAX_H) ? MAX_H : height_reg;

    assign bad = line_reg.start_x[7] || (line_reg.start_x[6:0] >= w_lim)
              || line_reg.start_y[7] || (line_reg.start_y[6:0] >= h_lim)
              || line_reg.end_x[7]   || (line_reg.end_x[6:0]   >= w_lim)
              || line_reg.end_y[7]   || (line_reg.end_y[6:0]   >= h_lim);

    assign diff_x = {1'b0, line_reg.end_x[COORD_W-1:0]} - {1'b0, line_reg.start_x[COORD_W-1:0]};
    assign diff_y = {1'b0, line_reg.end_y[COORD_W-1:0]} - {1'b0, line_reg.start_y[COORD_W-1:0]};
    assign adx  = diff_x[WIN_W-1] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
    assign ady  = diff_y[WIN_W-1] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
    assign span = (adx > ady) ? adx : ady;

    // step unit
    assign ex_sum  = ex_reg + {1'b0, dx_reg};
    assign ey_sum  = ey_reg + {1'b0, dy_reg};
    assign step_x  = ex_sum > {1'b0, dist_reg};
    assign step_y  = ey_sum > {1'b0, dist_reg};
    assign ex_next = step_x ? ex_sum - {1'b0, dist_reg} : ex_sum;
    assign ey_next = step_y ? ey_sum - {1'b0, dist_reg} : ey_sum;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_pixel  = m_pixel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_RUN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        line_reg  <= s_line;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    bad_reg    <= bad;
                    x_reg      <= line_reg.start_x[COORD_W-1:0];
                    y_reg      <= line_reg.start_y[COORD_W-1:0];
                    dx_reg     <= adx;
                    dy_reg     <= ady;
                    dist_reg   <= span;
                    sx_neg_reg <= diff_x[WIN_W-1];
                    sy_neg_reg <= diff_y[WIN_W-1];
                    ex_reg     <= {1'b0, adx};
                    ey_reg     <= {1'b0, ady};
                    cnt_reg    <= '0;
                    state_reg  <= ST_RUN;
                end
                ST_RUN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (bad_reg) begin
                            m_pixel_reg <= '{pixel_x: '0, pixel_y: '0, pixel_color: '0,
                                             bad_endpoint: 1'b1, last_pixel: 1'b1};
                            state_reg   <= ST_IDLE;
                        end else begin
                            m_pixel_reg <= '{pixel_x: x_reg, pixel_y: y_reg,
                                             pixel_color: line_reg.pen_color,
                                             bad_endpoint: 1'b0,
                                             last_pixel: (cnt_reg == dist_reg)};
                            ex_reg  <= ex_next;
                            ey_reg  <= ey_next;
                            cnt_reg <= cnt_reg + 1'b1;
                            if (step_x) begin
                                x_reg <= sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                            end
                            if (step_y) begin
                                y_reg <= sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                            end
                            if (cnt_reg == dist_reg) begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// testbench for line_rasterizer: directed line table, then randomized lines over several windows
// predicts the pixel writes of each line request and checks every result in order
// depends on lr_pkg and the line_rasterizer rtl
module testbench;
    import lr_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 21;
    localparam int NUM_PHASES   = 10;
    localparam int SHOWN_ERRORS = 40;

    typedef enum int {RX_STREAM, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

    typedef struct {
        lr_line_t  line;
        bit        typed;
        lr_pixel_t want;
    } line_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    lr_line_t    s_line = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    lr_pixel_t   m_pixel;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [WIN_W-1:0] win_width  = 7'd64;
    logic [WIN_W-1:0] win_height = 7'd64;

    lr_pixel_t pixel_q[$];
    line_row_t line_table[$];
    int        errors = 0;
    int        burst_left = 0;
    bit        hold_off = 1'b0;
    rx_mode_e  rx_mode = RX_STREAM;
    int        rx_left = 0;

    line_rasterizer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_line  (s_line),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_pixel (m_pixel),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic lr_pixel_t pix(int x, int y, int color, bit bad, bit last);
        lr_pixel_t p;
        p.pixel_x      = x[COORD_W-1:0];
        p.pixel_y      = y[COORD_W-1:0];
        p.pixel_color  = color[7:0];
        p.bad_endpoint = bad;
        p.last_pixel   = last;
        return p;
    endfunction

    function automatic int win_limit(logic [WIN_W-1:0] r, int cap);
        return (int'(r) > cap) ? cap : int'(r);
    endfunction

    function automatic bit on_window(int x, int y, int w, int h);
        return x >= 0 && x < w && y >= 0 && y < h;
    endfunction

    // bresenham stepping with one error accumulator per axis against the major distance
    function automatic void predict_pixels(lr_line_t line);
        int w, h, x0, y0, x1, y1, dx, dy, sx, sy, major, ex, ey, x, y;
        w  = win_limit(win_width, DEF_MAX_WIDTH);
        h  = win_limit(win_height, DEF_MAX_HEIGHT);
        x0 = int'(line.start_x);
        y0 = int'(line.start_y);
        x1 = int'(line.end_x);
        y1 = int'(line.end_y);
        if (!on_window(x0, y0, w, h) || !on_window(x1, y1, w, h)) begin
            pixel_q.push_back(pix(0, 0, 0, 1'b1, 1'b1));
            return;
        end
        dx    = x1 - x0;
        dy    = y1 - y0;
        sx    = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        sy    = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        dx    = (dx < 0) ? -dx : dx;
        dy    = (dy < 0) ? -dy : dy;
        major = (dx > dy) ? dx : dy;
        ex    = dx;
        ey    = dy;
        x     = x0;
        y     = y0;
        for (int t = 0; t <= major; t++) begin
            pixel_q.push_back(pix(x, y, int'(line.pen_color), 1'b0, t == major));
            ex += dx;
            ey += dy;
            if (ex > major) begin
                ex -= major;
                x  += sx;
            end
            if (ey > major) begin
                ey -= major;
                y  += sy;
            end
        end
    endfunction

    function automatic int pick_coord(int n);
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) == 0) ? 0 : n - 1;
        return $urandom_range(0, n - 1);
    endfunction

    // mostly endpoints inside the window, some raw noise across the full signed range
    function automatic lr_line_t rand_line();
        lr_line_t l;
        int w, h;
        w = win_limit(win_width, DEF_MAX_WIDTH);
        h = win_limit(win_height, DEF_MAX_HEIGHT);
        w = (w == 0) ? DEF_MAX_WIDTH : w;
        h = (h == 0) ? DEF_MAX_HEIGHT : h;
        l.pen_color = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 15) begin
            l.start_x = 8'($urandom);
            l.start_y = 8'($urandom);
            l.end_x   = 8'($urandom);
            l.end_y   = 8'($urandom);
        end else begin
            l.start_x = 8'(pick_coord(w));
            l.start_y = 8'(pick_coord(h));
            l.end_x   = 8'(pick_coord(w));
            l.end_y   = 8'(pick_coord(h));
            if ($urandom_range(0, 9) == 0) begin
                l.end_x = l.start_x;
                l.end_y = l.start_y;
            end
        end
        return l;
    endfunction

    task automatic add_row(int sx, int sy, int ex, int ey, int color, bit typed,
                           lr_pixel_t want);
        line_row_t r;
        r.line.start_x   = sx[7:0];
        r.line.start_y   = sy[7:0];
        r.line.end_x     = ex[7:0];
        r.line.end_y     = ey[7:0];
        r.line.pen_color = color[7:0];
        r.typed          = typed;
        r.want           = want;
        line_table.push_back(r);
    endtask

    task automatic write_reg(logic reg_sel, logic [WIN_W-1:0] value);
        logic [31:0] data;
        data = ($urandom & ~32'h7f) | 32'(value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_sel == REG_WINDOW_WIDTH)
            win_width = data[WIN_W-1:0];
        else
            win_height = data[WIN_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_line(lr_line_t line, bit typed, lr_pixel_t want);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_line  <= line;
        do @(posedge aclk); while (!s_ready);
        if (typed)
            pixel_q.push_back(want);
        else
            predict_pixels(line);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic drain_lines();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // receiver: random stall patterns, or one long hold-off when asked
    always begin
        @(negedge aclk);
        if (hold_off) begin
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge aclk);
            hold_off = 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_left = $urandom_range(10, 60);
            end
            rx_left--;
            case (rx_mode)
                RX_STREAM: m_ready <= 1'b1;
                RX_LIGHT:  m_ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:  m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ~m_ready;
            endcase
        end
    end

    always @(posedge aclk) begin
        lr_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("%0t ns: unexpected pixel, expected none, actual %p", $time,
                             m_pixel);
            end else begin
                want = pixel_q.pop_front();
                if (m_pixel !== want) begin
                    errors++;
                    if (errors <= SHOWN_ERRORS)
                        $display({"%0t ns: pixel mismatch, expected x=%0d y=%0d color=%0h ",
                                  "bad=%0b last=%0b, actual x=%0d y=%0d color=%0h ",
                                  "bad=%0b last=%0b"}, $time,
                                 want.pixel_x, want.pixel_y, want.pixel_color,
                                 want.bad_endpoint, want.last_pixel,
                                 m_pixel.pixel_x, m_pixel.pixel_y, m_pixel.pixel_color,
                                 m_pixel.bad_endpoint, m_pixel.last_pixel);
                end
            end
        end
    end

    initial begin
        int phase_w[NUM_PHASES];
        int phase_h[NUM_PHASES];
        lr_pixel_t bad_pixel;
        bad_pixel = pix(0, 0, 0, 1'b1, 1'b1);
        phase_w = '{1, 0, 64, 127, 100, 7, 64, 0, 0, 2};
        phase_h = '{1, 64, 0, 127, 9, 90, 64, 0, 0, 64};
        phase_w[7] = $urandom_range(1, 64);
        phase_h[7] = $urandom_range(1, 64);
        phase_w[8] = $urandom_range(1, 64);
        phase_h[8] = $urandom_range(1, 64);

        // default 64 x 64 window after reset
        add_row(0, 0, 0, 0, 8'h00, 1'b1, pix(0, 0, 8'h00, 1'b0, 1'b1));
        add_row(63, 63, 63, 63, 8'hff, 1'b1, pix(63, 63, 8'hff, 1'b0, 1'b1));
        add_row(-1, 0, 5, 5, 8'h11, 1'b1, bad_pixel);
        add_row(0, 0, 64, 0, 8'h22, 1'b1, bad_pixel);
        add_row(0, 0, 0, -128, 8'h33, 1'b1, bad_pixel);
        add_row(127, 127, 0, 0, 8'h44, 1'b1, bad_pixel);
        add_row(-128, -128, -128, -128, 8'h80, 1'b1, bad_pixel);
        add_row(0, 64, 3, 3, 8'h7f, 1'b1, bad_pixel);
        add_row(10, 10, 10, -1, 8'h01, 1'b1, bad_pixel);
        add_row(0, 0, 63, 0, 8'h5a, 1'b0, '0);
        add_row(63, 0, 0, 0, 8'ha5, 1'b0, '0);
        add_row(0, 0, 0, 63, 8'h0f, 1'b0, '0);
        add_row(0, 63, 0, 0, 8'hf0, 1'b0, '0);
        add_row(0, 0, 63, 63, 8'h3c, 1'b0, '0);
        add_row(63, 0, 0, 63, 8'hc3, 1'b0, '0);
        add_row(0, 0, 63, 1, 8'h99, 1'b0, '0);
        add_row(5, 10, 1, 30, 8'h66, 1'b0, '0);
        add_row(10, 10, 11, 10, 8'h12, 1'b0, '0);
        add_row(20, 20, 21, 22, 8'h34, 1'b0, '0);
        add_row(63, 63, 0, 0, 8'haa, 1'b0, '0);
        add_row(3, 40, 50, 7, 8'h55, 1'b0, '0);

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (line_table[i])
            send_line(line_table[i].line, line_table[i].typed, line_table[i].want);
        drain_lines();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_WINDOW_WIDTH, WIN_W'(phase_w[p]));
            write_reg(REG_WINDOW_HEIGHT, WIN_W'(phase_h[p]));
            if (p == 6)
                hold_off = 1'b1;
            repeat (PHASE_ITEMS) send_line(rand_line(), 1'b0, '0);
            drain_lines();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lr_pkg.sv
hw/rtl/line_rasterizer.sv
sim/testbench.sv
